// File: hw/rtl/iws_pkg.sv
// Shared constants and types of the interarrival window statistics unit.
`default_nettype none
package iws_pkg;
	localparam int TS_W = 48;
	localparam int IV_W = 24;
	localparam int CV_W = 21;
	localparam int CNT_W = 32;
	localparam int CFG_W = 24;
	localparam int IDX_W = 3;
	localparam int WINDOW_MAX_DEF = 256;

	localparam logic [IV_W-1:0] IV_MAX = {IV_W{1'b1}};
	localparam logic [CV_W-1:0] CV_MAX = {CV_W{1'b1}};

	localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
	localparam logic [IDX_W-1:0] REG_NEED_CNT = 3'd1;
	localparam logic [IDX_W-1:0] REG_BURST_LIMIT = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAP_LIMIT = 3'd3;

	localparam logic [8:0] WINDOW_LEN_RST = 9'd64;
	localparam logic [8:0] NEED_CNT_RST = 9'd2;
	localparam logic [IV_W-1:0] BURST_LIMIT_RST = 24'd5000;
	localparam logic [IV_W-1:0] GAP_LIMIT_RST = 24'd2000000;

	typedef struct packed {
		logic [IV_W-1:0] interval;
		logic ready;
		logic burst;
		logic gap;
		logic [CNT_W-1:0] burst_total;
		logic [CNT_W-1:0] gap_total;
		logic [CNT_W-1:0] arrival_total;
	} job_info_t;
endpackage
`default_nettype wire

// File: hw/rtl/iws_front.sv
// Front end: interval, window ring, running sums, burst and gap checks.
`default_nettype none
module iws_front import iws_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	localparam int FW = $clog2(WINDOW_MAX + 1),
	localparam int HW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int S1W = IV_W + FW,
	localparam int S2W = 2 * IV_W + FW
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [TS_W-1:0] arrival_time_us,
	input wire logic cfg_write,
	input wire logic [IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	output logic job_push,
	input wire logic job_full,
	output job_info_t job_info,
	output logic [FW-1:0] job_n,
	output logic [S1W-1:0] job_s1,
	output logic [S2W-1:0] job_s2
);
	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_READ = 4'b0010,
		F_SQ = 4'b0100,
		F_UPD = 4'b1000
	} fstate_t;

	fstate_t fst_q;
	logic [8:0] window_len_q, need_cnt_q;
	logic [IV_W-1:0] burst_limit_q, gap_limit_q;
	logic [TS_W-1:0] last_q;
	logic seen_q, first_q;
	logic [IV_W-1:0] iv_q, rd_q;
	logic [HW-1:0] head_q, headp_q, headp;
	logic [FW-1:0] fill_q, fill_n, win, hn;
	logic [S1W-1:0] s1_q, s1_n;
	logic [S2W-1:0] s2_q, s2_n;
	logic [2*IV_W-1:0] sqn_q, sqo_q;
	logic [CNT_W-1:0] burst_cnt_q, gap_cnt_q, arr_cnt_q;
	logic [IV_W-1:0] ring_q [WINDOW_MAX];
	logic [TS_W-1:0] diff;
	logic wrap, ready, burst, gap, cfg_hit;

	always_comb begin
		if (window_len_q == 9'd0) begin
			win = FW'(1);
		end else if (32'(window_len_q) > WINDOW_MAX) begin
			win = FW'(WINDOW_MAX);
		end else begin
			win = FW'(window_len_q);
		end
		headp = (FW'(head_q) >= win) ? '0 : head_q;
		hn = FW'(headp_q) + FW'(1);
		diff = arrival_time_us - last_q;
		wrap = fill_q >= win;
		fill_n = (first_q || wrap) ? fill_q : fill_q + FW'(1);
		if (first_q) begin
			s1_n = s1_q;
			s2_n = s2_q;
		end else if (wrap) begin
			s1_n = s1_q - S1W'(rd_q) + S1W'(iv_q);
			s2_n = s2_q - S2W'(sqo_q) + S2W'(sqn_q);
		end else begin
			s1_n = s1_q + S1W'(iv_q);
			s2_n = s2_q + S2W'(sqn_q);
		end
		ready = !first_q && (32'(fill_n) >= 32'(need_cnt_q));
		burst = ready && (iv_q < burst_limit_q);
		gap = ready && (iv_q > gap_limit_q);
		cfg_hit = cfg_write && (cfg_index == REG_WINDOW_LEN || cfg_index == REG_NEED_CNT ||
			cfg_index == REG_BURST_LIMIT || cfg_index == REG_GAP_LIMIT);
	end

	assign full = (fst_q != F_IDLE);
	assign job_push = (fst_q == F_UPD) && !job_full;
	assign job_n = fill_n;
	assign job_s1 = s1_n;
	assign job_s2 = s2_n;
	always_comb begin
		job_info.interval = iv_q;
		job_info.ready = ready;
		job_info.burst = burst;
		job_info.gap = gap;
		job_info.burst_total = burst_cnt_q + CNT_W'(burst);
		job_info.gap_total = gap_cnt_q + CNT_W'(gap);
		job_info.arrival_total = arr_cnt_q + CNT_W'(1);
	end

	// ring memory: registered read, one write per arrival after the first
	always_ff @(posedge clk) begin
		if (fst_q == F_READ) begin
			rd_q <= ring_q[headp];
		end
		if (job_push && !first_q) begin
			ring_q[headp_q] <= iv_q;
		end
	end

	always_ff @(posedge clk) begin
		case (fst_q)
			F_IDLE: begin
				if (push) begin
					if (!seen_q) begin
						iv_q <= '0;
					end else if (diff > TS_W'(IV_MAX)) begin
						iv_q <= IV_MAX;
					end else begin
						iv_q <= diff[IV_W-1:0];
					end
					first_q <= !seen_q;
				end
			end
			F_READ: begin
				headp_q <= headp;
				sqn_q <= {{IV_W{1'b0}}, iv_q} * {{IV_W{1'b0}}, iv_q};
			end
			F_SQ: begin
				sqo_q <= {{IV_W{1'b0}}, rd_q} * {{IV_W{1'b0}}, rd_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
			window_len_q <= WINDOW_LEN_RST;
			need_cnt_q <= NEED_CNT_RST;
			burst_limit_q <= BURST_LIMIT_RST;
			gap_limit_q <= GAP_LIMIT_RST;
			last_q <= '0;
			seen_q <= 1'b0;
			head_q <= '0;
			fill_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			burst_cnt_q <= '0;
			gap_cnt_q <= '0;
			arr_cnt_q <= '0;
		end else begin
			case (cfg_index)
				REG_WINDOW_LEN: if (cfg_write) window_len_q <= cfg_data[8:0];
				REG_NEED_CNT: if (cfg_write) need_cnt_q <= cfg_data[8:0];
				REG_BURST_LIMIT: if (cfg_write) burst_limit_q <= cfg_data;
				REG_GAP_LIMIT: if (cfg_write) gap_limit_q <= cfg_data;
				default: begin
				end
			endcase
			// any listed register write drops the window contents
			if (cfg_hit) begin
				head_q <= '0;
				fill_q <= '0;
				s1_q <= '0;
				s2_q <= '0;
			end
			case (fst_q)
				F_IDLE: if (push) fst_q <= F_READ;
				F_READ: fst_q <= F_SQ;
				F_SQ: fst_q <= F_UPD;
				F_UPD: begin
					if (!job_full) begin
						if (!first_q) begin
							head_q <= (hn >= win) ? '0 : hn[HW-1:0];
							fill_q <= fill_n;
							s1_q <= s1_n;
							s2_q <= s2_n;
						end
						burst_cnt_q <= job_info.burst_total;
						gap_cnt_q <= job_info.gap_total;
						arr_cnt_q <= job_info.arrival_total;
						seen_q <= 1'b1;
						fst_q <= F_IDLE;
					end
				end
				default: fst_q <= F_IDLE;
			endcase
			if (fst_q == F_IDLE && push) begin
				last_q <= arrival_time_us;
			end
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/iws_jobq.sv
// Two-entry request queue between front end and arithmetic back end.
`default_nettype none
module iws_jobq #(
	parameter int W = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr,
	input wire logic [W-1:0] wdata,
	output logic full,
	input wire logic rd,
	output logic [W-1:0] rdata,
	output logic empty
);
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) wp_q <= !wp_q;
			if (do_rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/iws_back.sv
// Back end: serial divide, multiply and square root for mean and CV.
`default_nettype none
module iws_back import iws_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	localparam int FW = $clog2(WINDOW_MAX + 1),
	localparam int S1W = IV_W + FW,
	localparam int S2W = 2 * IV_W + FW
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	output logic job_take,
	input wire job_info_t job_info,
	input wire logic [FW-1:0] job_n,
	input wire logic [S1W-1:0] job_s1,
	input wire logic [S2W-1:0] job_s2,
	output logic empty,
	input wire logic pop,
	output logic [IV_W-1:0] interval_us,
	output logic [IV_W-1:0] mean_us,
	output logic [CV_W-1:0] cv_q16,
	output logic stats_ready,
	output logic burst_flag,
	output logic gap_flag,
	output logic [CNT_W-1:0] burst_total,
	output logic [CNT_W-1:0] gap_total,
	output logic [CNT_W-1:0] arrival_total
);
	localparam int VW = S2W + FW;
	localparam int VE = VW + (VW % 2);
	localparam int RW = VE / 2;
	localparam int CMPW = RW + S1W + 5;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_DIVM = 7'b0000010,
		B_MULN = 7'b0000100,
		B_MULS = 7'b0001000,
		B_SQRT = 7'b0010000,
		B_DIVC = 7'b0100000,
		B_DONE = 7'b1000000
	} bstate_t;

	bstate_t bst_q;
	job_info_t info_q;
	logic [FW-1:0] n_q;
	logic [S1W-1:0] s1_q, s2_lo_unused;
	logic [S2W-1:0] s2_q;
	logic [VE-1:0] acc_q, mc_q;
	logic [S1W-1:0] mp_q;
	logic [6:0] cnt_q;
	logic [RW-1:0] root_q, root_n;
	logic [RW+1:0] rem_q, rem_n;
	logic [RW+3:0] r2, trial;
	logic [S1W-1:0] drem_q, dvs_q, drem_n;
	logic [S1W:0] dt;
	logic [IV_W-1:0] dlo_q, quot_q, quot_n, mean_q;
	logic [CV_W-1:0] cv_q;
	logic oval_q;

	assign s2_lo_unused = '0;
	assign empty = !oval_q;
	assign job_take = (bst_q == B_IDLE) && job_valid;

	// one restoring divide step and one square root digit step
	always_comb begin
		dt = {drem_q, dlo_q[IV_W-1]};
		if (dt >= {1'b0, dvs_q}) begin
			drem_n = S1W'(dt - {1'b0, dvs_q});
			quot_n = {quot_q[IV_W-2:0], 1'b1};
		end else begin
			drem_n = dt[S1W-1:0];
			quot_n = {quot_q[IV_W-2:0], 1'b0};
		end
		r2 = {rem_q, acc_q[VE-1:VE-2]};
		trial = {2'b00, root_q, 2'b01};
		if (r2 >= trial) begin
			rem_n = (RW+2)'(r2 - trial);
			root_n = {root_q[RW-2:0], 1'b1};
		end else begin
			rem_n = r2[RW+1:0];
			root_n = {root_q[RW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		case (bst_q)
			B_IDLE: begin
				info_q <= job_info;
				n_q <= job_n;
				s1_q <= job_s1 | s2_lo_unused;
				s2_q <= job_s2;
				mean_q <= '0;
				cv_q <= '0;
				drem_q <= S1W'(job_s1 >> IV_W);
				dlo_q <= job_s1[IV_W-1:0];
				dvs_q <= S1W'(job_n);
				quot_q <= '0;
				cnt_q <= '0;
			end
			B_DIVM: begin
				drem_q <= drem_n;
				dlo_q <= {dlo_q[IV_W-2:0], 1'b0};
				quot_q <= quot_n;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(IV_W - 1)) begin
					mean_q <= quot_n;
					acc_q <= '0;
					mc_q <= VE'(s2_q);
					mp_q <= S1W'(n_q);
					cnt_q <= '0;
				end
			end
			B_MULN: begin
				if (mp_q[0]) acc_q <= acc_q + mc_q;
				mc_q <= {mc_q[VE-2:0], 1'b0};
				mp_q <= mp_q >> 1;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(FW - 1)) begin
					mc_q <= VE'(s1_q);
					mp_q <= s1_q;
					cnt_q <= '0;
				end
			end
			B_MULS: begin
				if (mp_q[0]) acc_q <= acc_q - mc_q;
				mc_q <= {mc_q[VE-2:0], 1'b0};
				mp_q <= mp_q >> 1;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(S1W - 1)) begin
					root_q <= '0;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			B_SQRT: begin
				root_q <= root_n;
				rem_q <= rem_n;
				acc_q <= {acc_q[VE-3:0], 2'b00};
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(RW - 1)) begin
					// hold cv at full scale when the quotient would not fit
					if (CMPW'(root_n) >= (CMPW'(s1_q) << 5)) begin
						cv_q <= CV_MAX;
					end
					drem_q <= S1W'(root_n >> 5);
					dlo_q <= {root_n[4:0], 19'd0};
					dvs_q <= s1_q;
					quot_q <= '0;
					cnt_q <= '0;
				end
			end
			B_DIVC: begin
				drem_q <= drem_n;
				dlo_q <= {dlo_q[IV_W-2:0], 1'b0};
				quot_q <= quot_n;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(CV_W - 1)) begin
					cv_q <= quot_n[CV_W-1:0];
				end
			end
			B_DONE: begin
				if (!oval_q) begin
					interval_us <= info_q.interval;
					mean_us <= mean_q;
					cv_q16 <= cv_q;
					stats_ready <= info_q.ready;
					burst_flag <= info_q.burst;
					gap_flag <= info_q.gap;
					burst_total <= info_q.burst_total;
					gap_total <= info_q.gap_total;
					arrival_total <= info_q.arrival_total;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_IDLE;
			oval_q <= 1'b0;
		end else begin
			if (pop && oval_q) oval_q <= 1'b0;
			case (bst_q)
				B_IDLE: if (job_valid) bst_q <= job_info.ready ? B_DIVM : B_DONE;
				B_DIVM: begin
					if (cnt_q == 7'(IV_W - 1)) bst_q <= (s1_q == '0) ? B_DONE : B_MULN;
				end
				B_MULN: if (cnt_q == 7'(FW - 1)) bst_q <= B_MULS;
				B_MULS: if (cnt_q == 7'(S1W - 1)) bst_q <= B_SQRT;
				B_SQRT: begin
					if (cnt_q == 7'(RW - 1)) begin
						bst_q <= (CMPW'(root_n) >= (CMPW'(s1_q) << 5)) ? B_DONE : B_DIVC;
					end
				end
				B_DIVC: if (cnt_q == 7'(CV_W - 1)) bst_q <= B_DONE;
				B_DONE: begin
					if (!oval_q) begin
						oval_q <= 1'b1;
						bst_q <= B_IDLE;
					end
				end
				default: bst_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/interarrival_window_stats_unit.sv
// Interarrival statistics unit: arrivals in, one statistics record out per arrival.
// Each arrival passes the front end (interval, ring read, squares, window update),
// then waits in a two-entry request queue for the arithmetic back end. The back end
// only records an arrival without statistics, stops after the mean divide when the
// window sum is zero, skips the variation divide when the variation saturates, and
// otherwise runs the mean divide, the multiply by n, the subtract of the squared sum,
// the square root and the variation divide; it takes no new request until it is done
// with the last one. That serial divide, shift-add multiply and square root unit sets
// the sustained rate; a result left unpopped holds the back end until it is taken.
// The ring memory needs no clearing pass after reset; a write to any listed
// configuration register empties the window.
`default_nettype none
module interarrival_window_stats_unit import iws_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [TS_W-1:0] arrival_time_us,
	output logic empty,
	input wire logic pop,
	output logic [IV_W-1:0] interval_us,
	output logic [IV_W-1:0] mean_us,
	output logic [CV_W-1:0] cv_q16,
	output logic stats_ready,
	output logic burst_flag,
	output logic gap_flag,
	output logic [CNT_W-1:0] burst_total,
	output logic [CNT_W-1:0] gap_total,
	output logic [CNT_W-1:0] arrival_total,
	input wire logic cfg_write,
	input wire logic [IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);
	localparam int FW = $clog2(WINDOW_MAX + 1);
	localparam int S1W = IV_W + FW;
	localparam int S2W = 2 * IV_W + FW;
	localparam int JW = $bits(job_info_t) + FW + S1W + S2W;

	job_info_t f_info, b_info;
	logic [FW-1:0] f_n, b_n;
	logic [S1W-1:0] f_s1, b_s1;
	logic [S2W-1:0] f_s2, b_s2;
	logic job_push, job_full, job_take, job_empty;
	logic [JW-1:0] jq_rdata;

	iws_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
		.clk, .arst_n, .push, .full, .arrival_time_us,
		.cfg_write, .cfg_index, .cfg_data,
		.job_push, .job_full, .job_info(f_info), .job_n(f_n), .job_s1(f_s1), .job_s2(f_s2)
	);

	iws_jobq #(.W(JW)) u_jobq (
		.clk, .arst_n, .wr(job_push), .wdata({f_info, f_n, f_s1, f_s2}), .full(job_full),
		.rd(job_take), .rdata(jq_rdata), .empty(job_empty)
	);

	assign {b_info, b_n, b_s1, b_s2} = jq_rdata;

	iws_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
		.clk, .arst_n, .job_valid(!job_empty), .job_take, .job_info(b_info),
		.job_n(b_n), .job_s1(b_s1), .job_s2(b_s2), .empty, .pop,
		.interval_us, .mean_us, .cv_q16, .stats_ready, .burst_flag, .gap_flag,
		.burst_total, .gap_total, .arrival_total
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front end took a second request at once");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_push && job_full))
		else $error("request queue overrun");
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !stats_ready) |-> (mean_us == '0 && cv_q16 == '0 && !burst_flag && !gap_flag))
		else $error("statistics shown while not ready");
`endif
endmodule
`default_nettype wire
